// ===== src/mi4_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and the cofactor read schedule for the 4x4 inverse unit.
// No dependencies.
package mi4_pkg;

    localparam int IDX_W      = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_USER_W = 2;
    localparam int VALUE_W    = 16;
    localparam int CHUNK_W    = 24;
    localparam int RECIP_W    = 33;
    localparam int INV_W      = 32;
    localparam int DET_OUT_W  = 64;
    localparam int DIV_STEPS  = 33;

    // phases of one 3x3 minor term: A*B - C*D, then E times that
    localparam logic [2:0] PH_A = 3'd0;
    localparam logic [2:0] PH_B = 3'd1;
    localparam logic [2:0] PH_C = 3'd2;
    localparam logic [2:0] PH_D = 3'd3;
    localparam logic [2:0] PH_E = 3'd4;

    localparam logic [1:0] TERM_FIRST = 2'd0;
    localparam logic [1:0] TERM_LAST  = 2'd2;
    localparam logic [1:0] COL_LAST   = 2'd3;
    localparam logic [IDX_W-1:0] IDX_LAST = 4'd15;

    // Matrix address read for cofactor idx, term and phase.
    function automatic logic [IDX_W-1:0] cof_src_addr(input logic [IDX_W-1:0] idx,
                                                      input logic [1:0] term,
                                                      input logic [2:0] phase);
        logic [1:0] p;
        logic [1:0] q;
        logic [1:0] rs;
        logic [1:0] cs;
        logic [1:0] r;
        logic [1:0] c;
        case (term)
            2'd0:    begin p = 2'd1; q = 2'd2; end
            2'd1:    begin p = 2'd2; q = 2'd0; end
            default: begin p = 2'd0; q = 2'd1; end
        endcase
        case (phase)
            PH_A:    begin rs = 2'd1; cs = p;    end
            PH_B:    begin rs = 2'd2; cs = q;    end
            PH_C:    begin rs = 2'd1; cs = q;    end
            PH_D:    begin rs = 2'd2; cs = p;    end
            default: begin rs = 2'd0; cs = term; end
        endcase
        // skip the excluded row and column
        r = rs + ((rs >= idx[3:2]) ? 2'd1 : 2'd0);
        c = cs + ((cs >= idx[1:0]) ? 2'd1 : 2'd0);
        return {r, c};
    endfunction

endpackage

// ===== src/mi4_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mi4_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/matrix4_inverse_adjoint_unit.sv =====
`timescale 1ns / 1ps
// 4x4 fixed-point matrix inverse through the adjugate, top level.
// Depends on mi4_pkg and mi4_ram.
//
//  channel   dir  tdata (low bit up)                          tuser / tlast
//  s_axis    in   elem_index[3:0], elem_value[19:4], zero pad  tlast = last
//  m_axis    out  out_index[3:0], inv_value[35:4],             tuser = singular[0],
//                 det_value[99:36], zero pad                    saturated[1]; tlast = out_last
//
// Every request is written to the matrix RAM; a request with tlast also starts the
// inversion: cofactors (15 matrix RAM reads each, one read port), then the determinant,
// normalize and divide steps, then each result in NCH chunks through the shared chunk
// multiplier (NCH = 3 at 16-bit elements). s_axis_tready is low throughout; a stalled
// m_axis holds the sequencer at the result register.
// Reset clears control only; both RAMs read undefined until written.
module matrix4_inverse_adjoint_unit
    import mi4_pkg::*;
#(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // elem_index, elem_value
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // out_index, inv_value, det_value
    output logic [OUT_USER_W-1:0] m_axis_tuser,  // singular, saturated
    output logic                  m_axis_tlast
);

    localparam int EW     = ELEM_WIDTH;
    localparam int TW     = 2 * EW + 1;           // 2x2 minor
    localparam int COF_W  = 3 * EW + 2;           // cofactor
    localparam int DW     = 4 * EW + 4;           // determinant
    localparam int NCH    = (COF_W + CHUNK_W - 1) / CHUNK_W;
    localparam int MW     = NCH * CHUNK_W;
    localparam int PRD_W  = CHUNK_W + RECIP_W;
    localparam int PW     = MW + RECIP_W;
    localparam int DX     = (DW > DET_OUT_W) ? DW : DET_OUT_W + 1;
    localparam int SH_W   = $clog2(DW + 1);
    localparam int SA_W   = $clog2(DW + 8);
    localparam int CI_W   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IT_W   = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE, S_COF, S_COF_DRAIN, S_DET_RD, S_DET_MUL, S_DET_CHK,
        S_NORM, S_DIV, S_OUT_RD, S_OUT_MUL, S_OUT_FIN
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  is_idx_reg;
    logic [1:0]        is_term_reg;
    logic [2:0]        is_phase_reg;
    logic              pr_valid_reg;
    logic [IDX_W-1:0]  pr_idx_reg;
    logic [1:0]        pr_term_reg;
    logic [2:0]        pr_phase_reg;
    logic [1:0]        det_col_reg;
    logic [CI_W-1:0]   ch_reg;
    logic [IT_W-1:0]   it_reg;
    logic [IDX_W-1:0]  k_reg;

    // datapath
    logic signed [EW-1:0]    a_reg;
    logic signed [TW-1:0]    t_reg;
    logic signed [COF_W-1:0] acc_reg;
    logic signed [DW-1:0]    det_acc_reg;
    logic [PW-1:0]           pacc_reg;
    logic [DW-1:0]           norm_reg;
    logic [SH_W-1:0]         sh_reg;
    logic [SA_W-1:0]         shamt_reg;
    logic [DW:0]             rem_reg;
    logic [RECIP_W-1:0]      q_reg;
    logic                    dneg_reg;
    logic                    sing_reg;
    logic                    dsat_reg;
    logic [DET_OUT_W-1:0]    detbits_reg;

    logic                 in_fire;
    logic [VALUE_W-1:0]   in_value;
    logic [EW-1:0]        in_raw;
    logic                 mat_re;
    logic [IDX_W-1:0]     mat_raddr;
    logic signed [EW-1:0] mat_rd;
    logic                 cof_re;
    logic [IDX_W-1:0]     cof_raddr;
    logic signed [COF_W-1:0] cof_rd;
    logic                 cof_we;
    logic signed [COF_W-1:0] cof_wdata;

    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_value      = s_axis_tdata[IDX_W +: VALUE_W];
    assign in_raw        = EW'(in_value);

    // matrix RAM is written only while idle, so no read ever overlaps a write
    assign mat_re    = (state_reg == S_COF) || (state_reg == S_DET_RD);
    assign mat_raddr = (state_reg == S_COF) ? cof_src_addr(is_idx_reg, is_term_reg,
                                                           is_phase_reg)
                                            : {2'b00, det_col_reg};
    assign cof_re    = (state_reg == S_DET_RD) || (state_reg == S_OUT_RD);
    // results run row-major over the transposed cofactors
    assign cof_raddr = (state_reg == S_DET_RD) ? {2'b00, det_col_reg}
                                               : {k_reg[1:0], k_reg[3:2]};

    mi4_ram #(.WIDTH(EW), .DEPTH(16)) u_mat_ram (
        .clk   (clk),
        .we    (in_fire),
        .waddr (s_axis_tdata[IDX_W-1:0]),
        .wdata (in_raw),
        .re    (mat_re),
        .raddr (mat_raddr),
        .rdata (mat_rd)
    );

    mi4_ram #(.WIDTH(COF_W), .DEPTH(16)) u_cof_ram (
        .clk   (clk),
        .we    (cof_we),
        .waddr (pr_idx_reg),
        .wdata (cof_wdata),
        .re    (cof_re),
        .raddr (cof_raddr),
        .rdata (cof_rd)
    );

    // ---- cofactor stage: acts on the element read in the previous cycle ----
    logic signed [2*EW-1:0]  pair_prod;
    logic signed [3*EW:0]    term_prod;
    logic signed [COF_W-1:0] acc_sum;
    logic                    cof_odd;

    assign pair_prod = a_reg * mat_rd;
    assign term_prod = mat_rd * t_reg;
    assign acc_sum   = ((pr_term_reg == TERM_FIRST) ? COF_W'(0) : acc_reg)
                       + COF_W'(term_prod);
    assign cof_odd   = pr_idx_reg[2] ^ pr_idx_reg[0];
    assign cof_wdata = cof_odd ? -acc_sum : acc_sum;
    assign cof_we    = pr_valid_reg && (pr_phase_reg == PH_E) && (pr_term_reg == TERM_LAST);

    // ---- shared chunk multiplier: cofactor magnitude chunk times |elem| or q ----
    logic                cof_neg;
    logic [COF_W-1:0]    cof_mag;
    logic [MW-1:0]       cof_mag_pad;
    logic [EW-1:0]       elem_mag;
    logic [CHUNK_W-1:0]  mul_a;
    logic [RECIP_W-1:0]  mul_b;
    logic [PRD_W-1:0]    prod;
    logic [PW-1:0]       prod_sh;
    logic [DW-1:0]       det_add;
    logic                det_term_neg;

    assign cof_neg      = cof_rd[COF_W-1];
    assign cof_mag      = cof_neg ? COF_W'(-cof_rd) : COF_W'(cof_rd);
    assign cof_mag_pad  = MW'(cof_mag);
    assign elem_mag     = mat_rd[EW-1] ? EW'(-mat_rd) : EW'(mat_rd);
    assign mul_a        = cof_mag_pad[ch_reg * CHUNK_W +: CHUNK_W];
    assign mul_b        = (state_reg == S_DET_MUL) ? RECIP_W'(elem_mag) : q_reg;
    assign prod         = PRD_W'(mul_a) * PRD_W'(mul_b);
    assign prod_sh      = PW'(prod) << (ch_reg * CHUNK_W);
    assign det_add      = DW'(prod_sh);
    assign det_term_neg = mat_rd[EW-1] ^ cof_neg;

    // ---- determinant check ----
    logic signed [DX-1:0] det_x;
    logic                 det_fits;
    logic                 det_neg;
    logic [DW-1:0]        det_mag;

    assign det_x    = DX'(det_acc_reg);
    assign det_fits = (&det_x[DX-1:DET_OUT_W-1]) | ~(|det_x[DX-1:DET_OUT_W-1]);
    assign det_neg  = det_acc_reg[DW-1];
    assign det_mag  = det_neg ? DW'(-det_acc_reg) : DW'(det_acc_reg);

    // ---- restoring divide step ----
    logic          div_ge;
    logic [DW:0]   rem_sub;

    assign div_ge  = rem_reg >= {1'b0, norm_reg};
    assign rem_sub = div_ge ? (rem_reg - {1'b0, norm_reg}) : rem_reg;

    // ---- result scale and clip ----
    logic [PW-1:0]    pshift;
    logic             inv_neg;
    logic [INV_W-1:0] inv_lim;
    logic [INV_W-1:0] inv_m;
    logic             inv_sat;
    logic [INV_W-1:0] inv_clip;
    logic [INV_W-1:0] inv_bits;
    logic             out_free;

    assign pshift   = pacc_reg >> shamt_reg;
    assign inv_neg  = cof_neg ^ dneg_reg;
    assign inv_lim  = inv_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign inv_m    = pshift[INV_W-1:0];
    assign inv_sat  = (|pshift[PW-1:INV_W]) || (inv_m > inv_lim);
    assign inv_clip = inv_sat ? inv_lim : inv_m;
    assign inv_bits = sing_reg ? '0 : (inv_neg ? -inv_clip : inv_clip);
    assign out_free = !m_axis_tvalid || m_axis_tready;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pr_valid_reg)
        begin
            case (pr_phase_reg) inside
                PH_A, PH_C: a_reg <= mat_rd;
                PH_B:       t_reg <= TW'(pair_prod);
                PH_D:       t_reg <= t_reg - TW'(pair_prod);
                default:    acc_reg <= acc_sum;
            endcase
        end
        case (state_reg)
            S_COF_DRAIN: det_acc_reg <= '0;
            S_DET_MUL:   det_acc_reg <= det_term_neg ? det_acc_reg - det_add
                                                     : det_acc_reg + det_add;
            S_DET_CHK:
            begin
                sing_reg <= (det_acc_reg == '0);
                dneg_reg <= det_neg;
                dsat_reg <= !det_fits;
                if (det_acc_reg == '0)
                begin
                    detbits_reg <= '0;
                end
                else if (det_fits)
                begin
                    detbits_reg <= det_x[DET_OUT_W-1:0];
                end
                else
                begin
                    detbits_reg <= det_neg ? 64'h8000_0000_0000_0000
                                           : 64'h7FFF_FFFF_FFFF_FFFF;
                end
                norm_reg <= det_mag;
                sh_reg   <= '0;
            end
            S_NORM:
            begin
                // shift the leading one up to the top, a byte at a time when possible
                if (norm_reg[DW-1])
                begin
                    rem_reg   <= (DW + 1)'(1) << (DW - 1);
                    q_reg     <= '0;
                    shamt_reg <= SA_W'(DW + 7) - SA_W'(sh_reg);
                end
                else if (norm_reg[DW-1 -: 8] == 8'd0)
                begin
                    norm_reg <= norm_reg << 8;
                    sh_reg   <= sh_reg + SH_W'(8);
                end
                else
                begin
                    norm_reg <= norm_reg << 1;
                    sh_reg   <= sh_reg + SH_W'(1);
                end
            end
            S_DIV:
            begin
                q_reg   <= {q_reg[RECIP_W-2:0], div_ge};
                rem_reg <= {rem_sub[DW-1:0], 1'b0};
            end
            S_OUT_RD:  pacc_reg <= '0;
            S_OUT_MUL: pacc_reg <= pacc_reg + prod_sh;
            default: ;
        endcase
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            is_idx_reg    <= '0;
            is_term_reg   <= '0;
            is_phase_reg  <= PH_A;
            pr_valid_reg  <= 1'b0;
            pr_idx_reg    <= '0;
            pr_term_reg   <= '0;
            pr_phase_reg  <= PH_A;
            det_col_reg   <= '0;
            ch_reg        <= '0;
            it_reg        <= '0;
            k_reg         <= '0;
            m_axis_tvalid <= 1'b0;
            m_axis_tdata  <= '0;
            m_axis_tuser  <= '0;
            m_axis_tlast  <= 1'b0;
        end
        else
        begin
            // drop the result once taken, unless the next one loads in this cycle
            if (m_axis_tvalid && m_axis_tready && (state_reg != S_OUT_FIN))
            begin
                m_axis_tvalid <= 1'b0;
            end
            pr_valid_reg <= (state_reg == S_COF);
            pr_idx_reg   <= is_idx_reg;
            pr_term_reg  <= is_term_reg;
            pr_phase_reg <= is_phase_reg;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && s_axis_tlast)
                    begin
                        is_idx_reg   <= '0;
                        is_term_reg  <= TERM_FIRST;
                        is_phase_reg <= PH_A;
                        state_reg    <= S_COF;
                    end
                end
                S_COF:
                begin
                    // advance phase, then term, then cofactor
                    if (is_phase_reg == PH_E)
                    begin
                        is_phase_reg <= PH_A;
                        if (is_term_reg == TERM_LAST)
                        begin
                            is_term_reg <= TERM_FIRST;
                            if (is_idx_reg == IDX_LAST)
                            begin
                                state_reg <= S_COF_DRAIN;
                            end
                            else
                            begin
                                is_idx_reg <= is_idx_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            is_term_reg <= is_term_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        is_phase_reg <= is_phase_reg + 1'b1;
                    end
                end
                S_COF_DRAIN:
                begin
                    det_col_reg <= '0;
                    state_reg   <= S_DET_RD;
                end
                S_DET_RD:
                begin
                    ch_reg    <= '0;
                    state_reg <= S_DET_MUL;
                end
                S_DET_MUL:
                begin
                    ch_reg <= ch_reg + 1'b1;
                    if (ch_reg == CI_W'(NCH - 1))
                    begin
                        if (det_col_reg == COL_LAST)
                        begin
                            state_reg <= S_DET_CHK;
                        end
                        else
                        begin
                            det_col_reg <= det_col_reg + 1'b1;
                            state_reg   <= S_DET_RD;
                        end
                    end
                end
                S_DET_CHK:
                begin
                    k_reg     <= '0;
                    state_reg <= (det_acc_reg == '0) ? S_OUT_RD : S_NORM;
                end
                S_NORM:
                begin
                    if (norm_reg[DW-1])
                    begin
                        it_reg    <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_OUT_RD;
                    end
                end
                S_OUT_RD:
                begin
                    ch_reg    <= '0;
                    state_reg <= S_OUT_MUL;
                end
                S_OUT_MUL:
                begin
                    ch_reg <= ch_reg + 1'b1;
                    if (ch_reg == CI_W'(NCH - 1))
                    begin
                        state_reg <= S_OUT_FIN;
                    end
                end
                S_OUT_FIN:
                begin
                    // hold here while the result register still holds a result not yet taken
                    if (out_free)
                    begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata  <= {4'b0000, detbits_reg, inv_bits, k_reg};
                        m_axis_tuser  <= {!sing_reg && (inv_sat || dsat_reg), sing_reg};
                        m_axis_tlast  <= (k_reg == IDX_LAST);
                        k_reg         <= k_reg + 1'b1;
                        state_reg     <= (k_reg == IDX_LAST) ? S_IDLE : S_OUT_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ---- checks ----
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[IDX_W-1:0] == IDX_LAST)))
        else $error("tlast does not match result index");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[IDX_W +: INV_W] == '0 && !m_axis_tuser[1]))
        else $error("singular result carries a value or clip flag");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("last request did not start the inversion");

    a_cof_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        cof_we |-> (state_reg == S_COF || state_reg == S_COF_DRAIN))
        else $error("cofactor write outside the cofactor pass");

endmodule
